>>> design/tcwc_pkg.sv
// ----------------------------------------------------------------------------
// tcwc_pkg: shared types and constants for the congestion window engine
// Event kinds, sequencer states and the reciprocal constants of the shared
// multiplier.
// ----------------------------------------------------------------------------
package tcwc_pkg;

  // event kinds carried in tuser
  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_LOSS_REQ = 2'd1,
    OP_SAMPLE   = 2'd2,
    OP_UNDO     = 2'd3
  } op_t;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_QDIG = 9'b000000010,
    S_RDIG = 9'b000000100,
    S_CUT  = 9'b000001000,
    S_GROW = 9'b000010000,
    S_MUL1 = 9'b000100000,
    S_MUL2 = 9'b001000000,
    S_ADD  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  // ns to ms: shift by 6, then long division by 15625 in 16-bit digits
  localparam int DIG_W    = 16;
  localparam int REM_W    = 14;
  localparam int CNT_W    = 2;
  localparam int MS_SHIFT = 6;

  localparam logic [REM_W-1:0] DIG_DIV = 14'd15625;

  // ceil(2^44 / 15625), exact quotient for numerators below 2^30
  localparam logic [31:0] RECIP_MS    = 32'd1125899907;
  localparam int          RECIP_MS_SH = 44;

  // ceil(2^35 / 10), exact quotient for any 32-bit numerator
  localparam logic [31:0] RECIP_TEN    = 32'hCCCC_CCCD;
  localparam int          RECIP_TEN_SH = 35;

  // state reset values
  localparam logic [15:0] INIT_WINDOW_RST = 16'd10;
  localparam logic [31:0] SSTHRESH_RST    = 32'h7fff_ffff;
  localparam logic [31:0] BASE_RST        = 32'd1;
  localparam logic [31:0] SECOND_RST      = 32'd200;
  localparam logic [31:0] MIN_GROW        = 32'd2;

endpackage

>>> design/tcp_congestion_window_control.sv
// ----------------------------------------------------------------------------
// tcp_congestion_window_control: per-connection congestion window engine
// Handles init, loss threshold, rate sample and undo events and returns the
// window, slow-start threshold and recovery flag after each event.
// ----------------------------------------------------------------------------
//
// channel   direction  payload
// s_axis    in         tdata: now_ns, next_seq, had_losses, had_acks; tuser: op
// m_axis    out        tdata: window, slow_start_limit, in_recovery
// cfg       in         cfg_data: initial_window
//
// Init, loss threshold, undo and a rate sample that changes nothing go straight
// to the final state, from which the result register is loaded; ready returns only
// as the result is loaded. A loss cut is one pass through the shared 32x32 multiplier
// (reciprocal of ten). An acked sample shifts the elapsed time by 6 and runs four
// 16-bit digits of division by 15625, two multiplier passes a digit, and two more
// passes in slow start. A result held on m_axis stalls the sequencer in its final
// state until taken. Reset is synchronous and needs no clearing pass.
module tcp_congestion_window_control (
  input  logic         clk,
  input  logic         rst,
  // request
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // now_ns[63:0], next_seq[95:64], had_losses[96],
                                       // had_acks[97], zero fill
  input  logic [1:0]   s_axis_tuser,   // op[1:0]
  // result
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // window[31:0], slow_start_limit[63:32],
                                       // in_recovery[64], zero fill
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);
  import tcwc_pkg::*;

  state_t             state;
  logic [15:0]        initial_window;
  logic [31:0]        cwnd;
  logic [31:0]        ssthresh;
  logic               recovery_flag;
  logic [31:0]        recovery_seq;
  logic [31:0]        base_window;
  logic [31:0]        second_limit;
  logic [63:0]        phase_start_ns;

  logic [REM_W-1:0]   rem;
  logic [63:0]        dvd;
  logic [31:0]        quo;
  logic [DIG_W-1:0]   q_dig;
  logic [CNT_W-1:0]   cnt;
  logic [31:0]        prod;

  // request fields
  op_t                op;
  logic [63:0]        now_ns;
  logic [31:0]        next_seq;
  logic               had_losses;
  logic               had_acks;

  logic               accept;
  logic               loss_acts;
  logic [31:0]        cwnd9;
  logic [63:0]        elapsed_ns;
  logic [29:0]        cur;
  logic [29:0]        cur_left;
  logic [31:0]        t;
  logic [31:0]        rec_win;
  logic [31:0]        avoid_win;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic               out_free;

  assign op         = op_t'(s_axis_tuser);
  assign now_ns     = s_axis_tdata[63:0];
  assign next_seq   = s_axis_tdata[95:64];
  assign had_losses = s_axis_tdata[96];
  assign had_acks   = s_axis_tdata[97];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // loss in a sample acts outside recovery or past the recovery point
  assign loss_acts  = !recovery_flag || (next_seq > recovery_seq);
  assign cwnd9      = {cwnd[28:0], 3'b000} + cwnd;
  assign elapsed_ns = now_ns - phase_start_ns;

  // long division digit: partial remainder and next 16 bits of the dividend
  assign cur      = {rem, dvd[63:64-DIG_W]};
  assign cur_left = cur - mul_p[29:0];

  // post-division growth terms
  assign t         = quo;
  assign rec_win   = base_window + t;
  assign avoid_win = second_limit + {t[30:0], 1'b0};

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_QDIG: begin
        mul_a = {2'b00, cur};
        mul_b = RECIP_MS;
      end
      S_RDIG: begin
        mul_a = {16'd0, q_dig};
        mul_b = {18'd0, DIG_DIV};
      end
      S_CUT: begin
        mul_a = cwnd9;
        mul_b = RECIP_TEN;
      end
      S_MUL1: begin
        mul_a = {t[30:0], 1'b0};
        mul_b = t;
      end
      S_MUL2: begin
        mul_a = prod;
        mul_b = t;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_window <= INIT_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      initial_window <= cfg_data;
    end
  end

  // sequencer and connection state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cwnd           <= {16'd0, INIT_WINDOW_RST};
      ssthresh       <= SSTHRESH_RST;
      recovery_flag  <= 1'b0;
      recovery_seq   <= '0;
      base_window    <= BASE_RST;
      second_limit   <= SECOND_RST;
      phase_start_ns <= '0;
      cnt            <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_FIN;
            unique case (op)
              OP_INIT: begin
                cwnd           <= {16'd0, initial_window};
                phase_start_ns <= now_ns;
                recovery_flag  <= 1'b0;
                recovery_seq   <= '0;
              end
              OP_LOSS_REQ: begin
                phase_start_ns <= now_ns;
                recovery_flag  <= 1'b1;
                recovery_seq   <= next_seq;
                ssthresh       <= {1'b0, cwnd[31:1]};
              end
              OP_SAMPLE: begin
                if (had_losses) begin
                  if (loss_acts) begin
                    recovery_flag  <= 1'b1;
                    recovery_seq   <= next_seq;
                    second_limit   <= cwnd;
                    ssthresh       <= {1'b0, cwnd[31:1]};
                    phase_start_ns <= now_ns;
                    state          <= S_CUT;
                  end
                end else if (had_acks) begin
                  dvd   <= elapsed_ns >> MS_SHIFT;
                  quo   <= '0;
                  rem   <= '0;
                  cnt   <= '0;
                  state <= S_QDIG;
                end
              end
              OP_UNDO: begin
                if (cwnd < MIN_GROW) begin
                  cwnd <= MIN_GROW;
                end
              end
            endcase
          end
        end
        S_QDIG: begin
          // quotient digit by reciprocal multiplication
          q_dig <= mul_p[RECIP_MS_SH+DIG_W-1:RECIP_MS_SH];
          state <= S_RDIG;
        end
        S_RDIG: begin
          // remainder of this digit, shift in the quotient digit
          rem <= cur_left[REM_W-1:0];
          quo <= {quo[31-DIG_W:0], q_dig};
          dvd <= {dvd[63-DIG_W:0], {DIG_W{1'b0}}};
          cnt <= cnt + 1'b1;
          if (cnt == {CNT_W{1'b1}}) begin
            state <= S_GROW;
          end else begin
            state <= S_QDIG;
          end
        end
        S_CUT: begin
          // cut to nine tenths
          cwnd        <= {3'd0, mul_p[63:RECIP_TEN_SH]};
          base_window <= {3'd0, mul_p[63:RECIP_TEN_SH]};
          state       <= S_FIN;
        end
        S_GROW: begin
          state <= S_FIN;
          if (recovery_flag) begin
            // linear growth from the base, recovery ends at the second threshold
            cwnd <= (rec_win == '0) ? 32'd1 : rec_win;
            if (((rec_win == '0) ? 32'd1 : rec_win) >= second_limit) begin
              recovery_flag <= 1'b0;
            end
          end else if (cwnd < ssthresh) begin
            state <= S_MUL1;
          end else begin
            cwnd <= (avoid_win == '0) ? 32'd1 : avoid_win;
          end
        end
        S_MUL1: begin
          prod  <= mul_p[31:0];
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= mul_p[31:0];
          state <= S_ADD;
        end
        S_ADD: begin
          // cubic slow-start step, at least two
          cwnd  <= cwnd + ((prod < MIN_GROW) ? MIN_GROW : prod);
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_axis_tdata <= {7'd0, recovery_flag, ssthresh, cwnd};
    end
  end

  // division remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_QDIG || state == S_RDIG) |-> (rem < DIG_DIV))
    else $error("divider remainder out of range");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("request taken while busy");

  // loss threshold request enters recovery
  a_loss_req: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser == OP_LOSS_REQ) |=> recovery_flag)
    else $error("loss threshold request did not enter recovery");

  // window in recovery growth is never zero
  a_rec_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_GROW && recovery_flag) |=> (cwnd != '0))
    else $error("zero window after recovery growth");

  // a result is only loaded from the final state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_FIN))
    else $error("result loaded outside final state");

endmodule

>>> tb/sv/tb_tcp_congestion_window_control.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tcp_congestion_window_control: self-checking bench for the window engine
// Streams init, loss threshold, rate sample and undo requests through the
// engine with random bursts and result stalls. The bench keeps its own copy
// of the window state and checks every result field against it in order.
// ----------------------------------------------------------------------------
module tb_tcp_congestion_window_control;
  import tcwc_pkg::*;

  localparam longint unsigned MS          = 64'd1000000;
  localparam int              IDLE_LIMIT  = 5000;
  localparam int              DRAIN_WAIT  = 100;
  localparam int              PHASE_ITEMS = 78;

  typedef struct {
    op_t         op;
    logic [63:0] now_ns;
    logic [31:0] next_seq;
    logic        lost;
    logic        acked;
  } cc_event_t;

  typedef struct packed {
    logic [31:0] window;
    logic [31:0] ss_limit;
    logic        in_rec;
  } window_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;   // now_ns[63:0], next_seq[95:64], had_losses[96],
                                     // had_acks[97], zero fill
  logic [1:0]   s_axis_tuser = '0;   // op[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;        // window[31:0], slow_start_limit[63:32],
                                     // in_recovery[64], zero fill
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  cc_event_t      pending_events[$];
  window_result_t expected_windows[$];
  int             fail_count = 0;

  // predicted engine state
  logic [15:0] init_win_q;
  logic [31:0] win_q;
  logic [31:0] ssthresh_q;
  logic        in_rec_q;
  logic [31:0] rec_point_q;
  logic [31:0] base_q;
  logic [31:0] second_q;
  logic [63:0] phase_ns_q;

  tcp_congestion_window_control DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // state after reset
  function automatic void reset_window_state();
    init_win_q  = INIT_WINDOW_RST;
    win_q       = {16'd0, INIT_WINDOW_RST};
    ssthresh_q  = SSTHRESH_RST;
    in_rec_q    = 1'b0;
    rec_point_q = '0;
    base_q      = BASE_RST;
    second_q    = SECOND_RST;
    phase_ns_q  = '0;
  endfunction

  // apply one event to the predicted state and return the expected result
  function automatic window_result_t advance_window_state(cc_event_t ev);
    window_result_t res;
    logic [31:0]    elapsed_ms;
    logic [31:0]    cubic;
    logic [31:0]    scaled;
    case (ev.op)
      OP_INIT: begin
        win_q       = {16'd0, init_win_q};
        phase_ns_q  = ev.now_ns;
        in_rec_q    = 1'b0;
        rec_point_q = '0;
      end
      OP_LOSS_REQ: begin
        phase_ns_q  = ev.now_ns;
        in_rec_q    = 1'b1;
        rec_point_q = ev.next_seq;
        ssthresh_q  = win_q >> 1;
      end
      OP_SAMPLE: begin
        if (ev.lost) begin
          // a loss only counts once per recovery episode
          if (!in_rec_q || ev.next_seq > rec_point_q) begin
            in_rec_q    = 1'b1;
            rec_point_q = ev.next_seq;
            second_q    = win_q;
            ssthresh_q  = win_q >> 1;
            scaled      = win_q * 32'd9;
            win_q       = scaled / 32'd10;
            base_q      = win_q;
            phase_ns_q  = ev.now_ns;
          end
        end else if (ev.acked) begin
          elapsed_ms = 32'((ev.now_ns - phase_ns_q) / MS);
          if (in_rec_q) begin
            win_q = base_q + elapsed_ms;
            if (win_q == 32'd0) win_q = 32'd1;
            if (win_q >= second_q) in_rec_q = 1'b0;
          end else if (win_q < ssthresh_q) begin
            // slow start: cubic growth with a floor of two
            cubic = 32'd2 * elapsed_ms;
            cubic = cubic * elapsed_ms;
            cubic = cubic * elapsed_ms;
            if (cubic < MIN_GROW) cubic = MIN_GROW;
            win_q = win_q + cubic;
          end else begin
            win_q = second_q + 32'd2 * elapsed_ms;
            if (win_q == 32'd0) win_q = 32'd1;
          end
        end
      end
      OP_UNDO: begin
        if (win_q < MIN_GROW) win_q = MIN_GROW;
      end
    endcase
    res.window   = win_q;
    res.ss_limit = ssthresh_q;
    res.in_rec   = in_rec_q;
    return res;
  endfunction

  // sender: bursts of random length with random gaps
  int        burst_left = 0;
  int        gap_left = 0;
  cc_event_t driven_ev;

  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_windows.push_back(advance_window_state(driven_ev));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_events.size() != 0) begin
          driven_ev = pending_events.pop_front();
          s_axis_tdata <= {6'd0, driven_ev.acked, driven_ev.lost, driven_ev.next_seq,
                           driven_ev.now_ns};
          s_axis_tuser <= driven_ev.op;
          next_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // receiver: stall pattern switches to a random mode after a random interval
  int          stall_left = 0;
  int          stall_mode = 0;
  logic [7:0]  stall_tick = '0;

  always @(posedge clk) begin
    window_result_t exp_res;
    logic           ready;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_windows.size() == 0) begin
          $error("unexpected result: window %0d", m_axis_tdata[31:0]);
          fail_count++;
        end else begin
          exp_res = expected_windows.pop_front();
          if (m_axis_tdata[31:0] !== exp_res.window) begin
            $error("window: expected %0d, got %0d", exp_res.window, m_axis_tdata[31:0]);
            fail_count++;
          end
          if (m_axis_tdata[63:32] !== exp_res.ss_limit) begin
            $error("slow_start_limit: expected %0d, got %0d", exp_res.ss_limit,
                   m_axis_tdata[63:32]);
            fail_count++;
          end
          if (m_axis_tdata[64] !== exp_res.in_rec) begin
            $error("in_recovery: expected %0d, got %0d", exp_res.in_rec, m_axis_tdata[64]);
            fail_count++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       ready = 1'b1;
        1:       ready = 1'($urandom_range(0, 1));
        2:       ready = (stall_tick[1:0] == 2'd0);
        default: ready = stall_tick[3];
      endcase
      stall_tick++;
      m_axis_tready <= ready;
    end
  end

  // watchdog: too long without any handshake
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void queue_event(op_t op, logic [63:0] now_ns, logic [31:0] seq,
                                      logic lost, logic acked);
    cc_event_t ev;
    ev.op       = op;
    ev.now_ns   = now_ns;
    ev.next_seq = seq;
    ev.lost     = lost;
    ev.acked    = acked;
    pending_events.push_back(ev);
  endfunction

  // called with the clock just risen, returns just after the write is taken
  task automatic write_initial_window(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    init_win_q = value;
  endtask

  // quiet on consecutive edges, so a request launched at the same edge is seen
  task automatic wait_engine_idle();
    int quiet;
    quiet = 0;
    while (quiet < 2) begin
      @(posedge clk);
      if (pending_events.size() == 0 && !s_axis_tvalid && expected_windows.size() == 0)
        quiet++;
      else
        quiet = 0;
    end
  endtask

  // well-formed connection traffic with random content, plus some noise
  task automatic queue_connection_traffic(input int count);
    logic [63:0] stamp;
    logic [31:0] seq;
    int          kind;
    stamp = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 1000)) * MS;
    seq   = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 1000));
    queue_event(OP_INIT, stamp, seq, 1'b0, 1'b0);
    for (int i = 1; i < count; i++) begin
      stamp = stamp + 64'($urandom_range(0, 12)) * MS + 64'($urandom_range(0, 999999));
      seq   = seq + 32'($urandom_range(0, 50));
      kind  = $urandom_range(0, 99);
      if (kind < 55) begin
        queue_event(OP_SAMPLE, stamp, seq, 1'b0, 1'b1);
      end else if (kind < 67) begin
        if ($urandom_range(0, 4) == 0) seq = seq - 32'($urandom_range(1, 100));
        else seq = seq + 32'($urandom_range(0, 200));
        queue_event(OP_SAMPLE, stamp, seq, 1'b1, 1'($urandom_range(0, 1)));
      end else if (kind < 72) begin
        queue_event(OP_SAMPLE, stamp, seq, 1'b0, 1'b0);
      end else if (kind < 78) begin
        queue_event(OP_LOSS_REQ, stamp, seq, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (kind < 84) begin
        queue_event(OP_UNDO, stamp, seq, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (kind < 89) begin
        queue_event(OP_INIT, stamp, seq, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        queue_event(op_t'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  logic [15:0] window_plan[8];

  initial begin
    reset_window_state();
    window_plan = '{16'd65535, 16'd0, 16'd1, 16'd0, 16'd2, 16'd0, 16'd65535, 16'd0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset state, growth modes, recovery gating, extremes
    queue_event(OP_SAMPLE, 64'd0, 32'd0, 1'b0, 1'b1);
    queue_event(OP_INIT, 64'd0, 32'd0, 1'b0, 1'b0);
    queue_event(OP_SAMPLE, 1 * MS, 32'd1, 1'b0, 1'b1);
    queue_event(OP_SAMPLE, 4 * MS, 32'd2, 1'b0, 1'b1);
    // sample with neither loss nor ack changes nothing
    queue_event(OP_SAMPLE, 5 * MS, 32'd3, 1'b0, 1'b0);
    queue_event(OP_SAMPLE, 6 * MS, 32'd100, 1'b1, 1'b0);
    // loss at or below the recovery point is ignored
    queue_event(OP_SAMPLE, 7 * MS, 32'd50, 1'b1, 1'b1);
    queue_event(OP_SAMPLE, 7 * MS, 32'd100, 1'b1, 1'b0);
    queue_event(OP_SAMPLE, 9 * MS, 32'd120, 1'b0, 1'b1);
    queue_event(OP_SAMPLE, 900 * MS, 32'd130, 1'b0, 1'b1);
    queue_event(OP_SAMPLE, 950 * MS, 32'd140, 1'b0, 1'b1);
    queue_event(OP_LOSS_REQ, '1, '1, 1'b1, 1'b1);
    queue_event(OP_SAMPLE, '1, '1, 1'b1, 1'b0);
    // time going backwards wraps around, here to an elapsed time of one nanosecond
    queue_event(OP_SAMPLE, 64'd0, 32'd0, 1'b0, 1'b1);
    queue_event(OP_UNDO, '1, '1, 1'b0, 1'b0);
    queue_event(OP_SAMPLE, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, 1'b1);
    queue_event(OP_INIT, '1, '1, 1'b1, 1'b1);
    queue_event(OP_SAMPLE, 64'd0, 32'd0, 1'b0, 1'b1);
    queue_event(OP_UNDO, 64'd0, 32'd0, 1'b0, 1'b0);
    wait_engine_idle();

    for (int p = 0; p < 8; p++) begin
      if (window_plan[p] == 16'd0 && p != 1) window_plan[p] = 16'($urandom_range(1, 65535));
      write_initial_window(window_plan[p]);
      if (p == 1) begin
        // zero initial window loads as is, undo lifts it to two
        queue_event(OP_INIT, 64'd0, 32'd0, 1'b0, 1'b0);
        queue_event(OP_UNDO, 64'd0, 32'd0, 1'b0, 1'b0);
        queue_event(OP_INIT, 64'd10, 32'd0, 1'b0, 1'b0);
        queue_event(OP_SAMPLE, 64'd20, 32'd0, 1'b1, 1'b0);
        queue_event(OP_SAMPLE, 3 * MS, 32'd1, 1'b0, 1'b1);
      end
      queue_connection_traffic(PHASE_ITEMS);
      wait_engine_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && expected_windows.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
